// ===== design/bte_pkg.sv =====
// Shared types and constants for the 4x4 block truncation encoder.
// No dependencies; imported by every module of the encoder.
package bte_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int PIX_W      = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = 12;
  localparam int WID_W      = 11;
  localparam int HGT_W      = 13;
  localparam int ADDR_W     = $clog2(3 * MAX_WIDTH);
  localparam int SUM_W      = 12;
  localparam int NUM_W      = 13;
  localparam int DEN_W      = 6;
  localparam int CNT_W      = 4;
  localparam int NPIX       = 16;
  localparam int NSTORED    = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int OUT_W      = 32;

  localparam logic [WID_W-1:0] WIDTH_RST  = WID_W'(640);
  localparam logic [HGT_W-1:0] HEIGHT_RST = HGT_W'(480);

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = CFG_IDX_W'(1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_MEAN,
    S_CMP,
    S_DIVH_GO,
    S_DIVH_WAIT,
    S_DIVL_GO,
    S_DIVL_WAIT,
    S_DONE
  } bte_state_t;

  typedef struct packed {
    logic             pix_acc;
    logic             rd_en;
    logic [CNT_W-1:0] rd_idx;
    logic             mean_ld;
    logic             cmp_en;
    logic [CNT_W-1:0] cmp_idx;
    logic             div_start;
    logic             div_sel_hi;
    logic             cap_hi;
    logic             cap_lo;
    logic             out_load;
  } bte_cmd_t;

  typedef struct packed {
    logic blk_end;
    logic div_busy;
    logic div_done;
    logic out_free;
  } bte_sts_t;

endpackage

// ===== design/block_truncation_encoder.sv =====
// Top level of the 4x4 absolute-moment block truncation encoder.
// Depends on bte_pkg, bte_ctrl and bte_datapath (which holds bte_div).
//
//   channel  direction  transaction     payload
//   in_      slave      one pixel       tdata[7:0] pixel
//   out_     master     one block code  tdata mean_high/mean_low/bit_mask, tlast frame_end
//   cfg_     slave      register write  cfg_index, cfg_data (always ready)
//
// A pixel that does not finish a block is taken without stalling. The pixel that
// finishes a block is taken and then stalls the input while the block is encoded:
// 12 row-store reads through the single read port and a state for the last read
// to land, 1 mean, 16 compares and two 13-step divisions with their start and
// finish states, plus any wait for the output register.
// Reset (rst_n, synchronous) restores width 640, height 480 and zeroes both
// counters; the row store has no reset. Results wait in an output register
// while new pixels are taken.
module block_truncation_encoder import bte_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [PIX_W-1:0]      in_tdata,   // [7:0] pixel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata,  // [7:0] mean_high, [15:8] mean_low, [31:16] bit_mask
  output logic                  out_tlast,  // frame_end
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  bte_cmd_t cmd;
  bte_sts_t sts;

  assign cfg_ready = 1'b1;

  bte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bte_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .pixel      (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== design/bte_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on bte_pkg for operand widths.
module bte_div import bte_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [PIX_W-1:0] quot
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] it_r, it_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W:0]   trial;
  logic             qbit;

  assign trial = {rem_r, q_r[NUM_W-1]};
  assign qbit  = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    it_nxt   = it_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      it_nxt   = '0;
      rem_nxt  = '0;
      q_nxt    = num;
    end else if (busy_r) begin
      rem_nxt = qbit ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
      q_nxt   = {q_r[NUM_W-2:0], qbit};
      it_nxt  = it_r + CNT_W'(1);
      if (it_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      it_r   <= it_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r[PIX_W-1:0];

endmodule

// ===== design/bte_datapath.sv =====
// Datapath: counters, row store, block pixel buffer, accumulators, divider, output register.
// Depends on bte_pkg and bte_div; driven by bte_ctrl through bte_cmd_t.
module bte_datapath import bte_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bte_cmd_t              cmd,
  output bte_sts_t              sts,
  input  logic [PIX_W-1:0]      pixel,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata,
  output logic                  out_tlast
);

  logic [WID_W-1:0]  w_eff_r;
  logic [HGT_W-1:0]  h_eff_r;
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic [23:0]       prev_r;
  logic [COL_W-1:0]  blk_col_r;
  logic              blk_last_r;
  logic [PIX_W-1:0]  row_store [3*MAX_WIDTH];
  logic [PIX_W-1:0]  mem_q_r;
  logic              rd_v_r;
  logic [CNT_W-1:0]  rd_idx_d_r;
  logic [PIX_W-1:0]  px_r [NPIX];
  logic [SUM_W-1:0]  sum_r;
  logic [PIX_W-1:0]  mean_r;
  logic [NPIX-1:0]   mask_r;
  logic [SUM_W-1:0]  shi_r;
  logic [4:0]        nhi_r;
  logic [PIX_W-1:0]  mh_r;
  logic [PIX_W-1:0]  ml_r;
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;
  logic              out_last_r;

  logic [WID_W-1:0]  w4;
  logic [HGT_W-1:0]  h4;
  logic [1:0]        sub;
  logic              blk_end;
  logic              frame_last;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [SUM_W-1:0]  sum_tail;
  logic [SUM_W-1:0]  sum_plus;
  logic [PIX_W-1:0]  cmp_px;
  logic              gt;
  logic [SUM_W-1:0]  slo;
  logic [4:0]        nlo;
  logic [SUM_W-1:0]  div_s;
  logic [4:0]        div_n;
  logic [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic              div_busy;
  logic              div_done;
  logic [PIX_W-1:0]  div_q;

  function automatic logic [WID_W-1:0] clamp_w(input logic [WID_W-1:0] v);
    if (v < WID_W'(4)) begin
      return WID_W'(4);
    end else if (v > WID_W'(MAX_WIDTH)) begin
      return WID_W'(MAX_WIDTH);
    end
    return v;
  endfunction

  function automatic logic [HGT_W-1:0] clamp_h(input logic [HGT_W-1:0] v);
    if (v < HGT_W'(4)) begin
      return HGT_W'(4);
    end else if (v > HGT_W'(MAX_HEIGHT)) begin
      return HGT_W'(MAX_HEIGHT);
    end
    return v;
  endfunction

  assign w4  = {w_eff_r[WID_W-1:2], 2'b00};
  assign h4  = {h_eff_r[HGT_W-1:2], 2'b00};
  assign sub = row_r[1:0];

  // Remainder columns and rows beyond the last full block produce no code.
  assign blk_end = (sub == 2'd3) && (col_r[1:0] == 2'd3) &&
                   ({1'b0, col_r} < w4) && ({1'b0, row_r} < h4);
  assign frame_last = ({1'b0, row_r} == h4 - HGT_W'(1)) &&
                      ({1'b0, col_r} == w4 - WID_W'(1));

  // Configuration registers hold the clamped values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r <= WIDTH_RST;
      h_eff_r <= HEIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WIDTH:  w_eff_r <= clamp_w(cfg_data[WID_W-1:0]);
        CFG_HEIGHT: h_eff_r <= clamp_h(cfg_data[HGT_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  // Raster position counters and the fourth-row shift register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      prev_r <= '0;
    end else if (cmd.pix_acc) begin
      if (sub == 2'd3) begin
        prev_r <= {prev_r[15:0], pixel};
      end
      if ({1'b0, col_r} >= w_eff_r - WID_W'(1)) begin
        col_r <= '0;
        if ({1'b0, row_r} >= h_eff_r - HGT_W'(1)) begin
          row_r <= '0;
        end else begin
          row_r <= row_r + ROW_W'(1);
        end
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  assign wr_addr = ADDR_W'(sub) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_r);
  assign rd_addr = ADDR_W'(cmd.rd_idx[3:2]) * ADDR_W'(MAX_WIDTH) +
                   ADDR_W'(blk_col_r) + ADDR_W'(cmd.rd_idx[1:0]) - ADDR_W'(3);

  always_ff @(posedge clk) begin
    if (cmd.pix_acc && (sub != 2'd3)) begin
      row_store[wr_addr] <= pixel;
    end
    if (cmd.rd_en) begin
      mem_q_r <= row_store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= cmd.rd_en;
    end
  end

  assign sum_tail = SUM_W'(prev_r[23:16]) + SUM_W'(prev_r[15:8]) +
                    SUM_W'(prev_r[7:0]) + SUM_W'(pixel);
  assign sum_plus = sum_r + SUM_W'(8);
  assign cmp_px   = px_r[cmd.cmp_idx];
  assign gt       = (cmp_px > mean_r);

  // The bottom row of the block comes from the shift register and the input;
  // the upper three rows stream in from the row store.
  always_ff @(posedge clk) begin
    rd_idx_d_r <= cmd.rd_idx;
    if (cmd.pix_acc && blk_end) begin
      px_r[12]   <= prev_r[23:16];
      px_r[13]   <= prev_r[15:8];
      px_r[14]   <= prev_r[7:0];
      px_r[15]   <= pixel;
      sum_r      <= sum_tail;
      blk_col_r  <= col_r;
      blk_last_r <= frame_last;
    end else if (rd_v_r) begin
      px_r[rd_idx_d_r] <= mem_q_r;
      sum_r            <= sum_r + SUM_W'(mem_q_r);
    end
    if (cmd.mean_ld) begin
      mean_r <= sum_plus[SUM_W-1:4];
      mask_r <= '0;
      shi_r  <= '0;
      nhi_r  <= '0;
    end else if (cmd.cmp_en) begin
      mask_r <= {mask_r[NPIX-2:0], gt};
      if (gt) begin
        shi_r <= shi_r + SUM_W'(cmp_px);
        nhi_r <= nhi_r + 5'd1;
      end
    end
  end

  assign slo     = sum_r - shi_r;
  assign nlo     = 5'd16 - nhi_r;
  assign div_s   = cmd.div_sel_hi ? shi_r : slo;
  assign div_n   = cmd.div_sel_hi ? nhi_r : nlo;
  assign div_num = {div_s, 1'b0} + NUM_W'(div_n);
  assign div_den = {div_n, 1'b0};

  bte_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.cap_hi) begin
      mh_r <= (nhi_r == 5'd0) ? '0 : div_q;
    end
    if (cmd.cap_lo) begin
      ml_r <= div_q;
    end
    if (cmd.out_load) begin
      out_data_r <= {mask_r, ml_r, mh_r};
      out_last_r <= blk_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.blk_end  = blk_end;
  assign sts.div_busy = div_busy;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // Every above-mean pixel exceeds every other pixel, so the high level never
  // falls below the low level when any bit of the mask is set.
  a_levels_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (out_data_r[31:16] == '0) || (out_data_r[7:0] >= out_data_r[15:8]))
    else $error("high level below low level in a loaded code");

endmodule

// ===== design/bte_ctrl.sv =====
// Controller state machine: pixel intake, block read-out, mean, compare, divisions, output load.
// Depends on bte_pkg; commands bte_datapath through bte_cmd_t.
module bte_ctrl import bte_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  bte_sts_t sts,
  output bte_cmd_t cmd
);

  bte_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_tvalid && sts.blk_end) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        // The final S_READ state issues no read and lets the last registered read land in the buffer.
        if (cnt_r == CNT_W'(NSTORED)) begin
          state_nxt = S_MEAN;
        end
      end
      S_MEAN: begin
        cnt_nxt   = '0;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NPIX - 1)) begin
          state_nxt = S_DIVH_GO;
        end
      end
      S_DIVH_GO:   state_nxt = S_DIVH_WAIT;
      S_DIVH_WAIT: if (sts.div_done) begin
        state_nxt = S_DIVL_GO;
      end
      S_DIVL_GO:   state_nxt = S_DIVL_WAIT;
      S_DIVL_WAIT: if (sts.div_done) begin
        state_nxt = S_DONE;
      end
      S_DONE: if (sts.out_free) begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    cmd.rd_idx  = cnt_r;
    cmd.cmp_idx = cnt_r;
    case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.pix_acc = in_tvalid;
      end
      S_READ:      cmd.rd_en = (cnt_r < CNT_W'(NSTORED));
      S_MEAN:      cmd.mean_ld = 1'b1;
      S_CMP:       cmd.cmp_en = 1'b1;
      S_DIVH_GO: begin
        cmd.div_start  = 1'b1;
        cmd.div_sel_hi = 1'b1;
      end
      S_DIVH_WAIT: cmd.cap_hi = sts.div_done;
      S_DIVL_GO:   cmd.div_start = 1'b1;
      S_DIVL_WAIT: cmd.cap_lo = sts.div_done;
      S_DONE:      cmd.out_load = sts.out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_block_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && sts.blk_end) |=> !in_tready)
    else $error("input taken while a block is being encoded");

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider started while busy");

  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == S_DIVH_WAIT || state_r == S_DIVL_WAIT))
    else $error("divider finished outside a wait state");

endmodule
